>>> hw/rtl/detection_query_decoder_assert.svh
// Assertion macros used by the detection query decoder controller.
`ifndef DETECTION_QUERY_DECODER_ASSERT_SVH
`define DETECTION_QUERY_DECODER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DQD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define DQD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/dqd_pkg.sv
`timescale 1ns / 1ps
package dqd_pkg;

    localparam int unsigned LOGIT_W = 16;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned POS_W   = 9;
    localparam int unsigned DIV_W   = 6;
    localparam logic [SUM_W-1:0] SUM_ONE = 32'd65536;
    localparam logic [POS_W-1:0] POS_SAT = 9'd511;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_CLASSES   = 2'd1;
    localparam logic [1:0] REG_WIDTH     = 2'd2;
    localparam logic [1:0] REG_HEIGHT    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_BOX,
        ST_EMIT
    } dqd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic div_start;
        logic div_step;
        logic box;
        logic clear;
    } dqd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_last;
        logic div_done;
        logic pass;
    } dqd_status_t;

endpackage

>>> hw/rtl/dqd_ctrl.sv
`timescale 1ns / 1ps
`include "detection_query_decoder_assert.svh"
module dqd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dqd_pkg::dqd_cmd_t    cmd,
    input  dqd_pkg::dqd_status_t status
);
    import dqd_pkg::*;

    dqd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_stall = 1'b0;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                if (status.is_last) begin
                    state_next = ST_START;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            // The divider loads only after the last logit has entered the sum.
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_BOX;
                end
            end
            ST_BOX: begin
                cmd.box   = 1'b1;
                cmd.clear = 1'b1;
                state_next = status.pass ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                out_valid = 1'b1;
                if (!out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `DQD_ASSERT_IMPL(a_out_only_emit, out_valid, state_reg == ST_EMIT)
    `DQD_ASSERT_NEXT(a_capture_update, cmd.capture, state_reg == ST_UPDATE)
    `DQD_ASSERT_IMPL(a_no_take_busy, !in_stall, state_reg == ST_IDLE)

endmodule

>>> hw/rtl/dqd_datapath.sv
`timescale 1ns / 1ps
module dqd_datapath #(
    parameter int unsigned MAX_CLASSES     = 256,
    parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dqd_pkg::dqd_cmd_t    cmd,
    output dqd_pkg::dqd_status_t status,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_sel,
    input  logic                 cfg_known,
    input  logic [15:0]          cfg_data,
    input  logic signed [15:0]   logit,
    input  logic                 last_in_query,
    input  logic [15:0]          center_x,
    input  logic [15:0]          center_y,
    input  logic [15:0]          norm_width,
    input  logic [15:0]          norm_height,
    output logic signed [18:0]   x_left,
    output logic signed [18:0]   y_top,
    output logic [17:0]          box_width,
    output logic [17:0]          box_height,
    output logic [15:0]          score,
    output logic [7:0]           class_id
);
    import dqd_pkg::*;

    localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);

    // Exponential table built at elaboration by the fixed-point recursion.
    function automatic logic [16:0] exp_entry(input int unsigned n);
        logic [63:0] e;
        logic [63:0] p;
        e = 64'd1 << 32;
        for (int unsigned k = 0; k < n; k++) begin
            p = (e >> 1) * 64'd4228380000 + (64'd1 << 30);
            e = p >> 31;
        end
        p = (e + 64'd32768) >> 16;
        return p[16:0];
    endfunction

    logic [16:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
        assign exp_rom[g] = exp_entry(g);
    end

    logic [15:0] thr_reg;
    logic [8:0]  ncls_reg;
    logic [13:0] imw_reg, imh_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            thr_reg  <= 16'd32768;
            ncls_reg <= 9'd80;
            imw_reg  <= 14'd640;
            imh_reg  <= 14'd640;
        end else if (cfg_write && cfg_known) begin
            case (cfg_sel)
                REG_THRESHOLD: thr_reg  <= cfg_data;
                REG_CLASSES:   ncls_reg <= cfg_data[8:0];
                REG_WIDTH:     imw_reg  <= cfg_data[13:0];
                REG_HEIGHT:    imh_reg  <= cfg_data[13:0];
                default:       thr_reg  <= thr_reg;
            endcase
        end
    end

    // Captured request.
    logic signed [15:0] x_reg;
    logic               last_reg;
    logic [15:0]        cx_reg, cy_reg, w_reg, h_reg;

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            x_reg    <= logit;
            last_reg <= last_in_query;
            cx_reg   <= center_x;
            cy_reg   <= center_y;
            w_reg    <= norm_width;
            h_reg    <= norm_height;
        end
    end

    logic signed [15:0] max_reg, best_reg;
    logic [31:0]        sum_reg;
    logic [7:0]         bidx_reg;
    logic [8:0]         pos_reg;

    function automatic logic [16:0] exp_lookup(input logic [16:0] d,
                                               input logic [16:0] rom_val);
        logic [17:0] i;
        i = ({1'b0, d} + 18'd2) >> 2;
        return (i >= 18'(EXP_TABLE_DEPTH)) ? 17'd0 : rom_val;
    endfunction

    logic signed [16:0] diff;
    logic [16:0]        dmag, e_upd;
    logic [17:0]        didx;
    logic [47:0]        prod;
    logic [48:0]        grow;
    logic [32:0]        addsum;
    logic               gt_max;

    always_comb begin
        gt_max = x_reg > max_reg;
        diff   = gt_max ? (17'(x_reg) - 17'(max_reg)) : (17'(max_reg) - 17'(x_reg));
        dmag   = diff;
        didx   = ({1'b0, dmag} + 18'd2) >> 2;
        e_upd  = exp_lookup(dmag, exp_rom[didx[IDX_W-1:0]]);
        prod   = 48'(sum_reg) * 48'(e_upd);
        grow   = 49'((prod + 48'd32768) >> 16) + 49'(SUM_ONE);
        addsum = 33'(sum_reg) + 33'(e_upd);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_reg  <= '0;
            best_reg <= '0;
            sum_reg  <= '0;
            bidx_reg <= '0;
            pos_reg  <= '0;
        end else if (cmd.clear) begin
            max_reg  <= '0;
            best_reg <= '0;
            sum_reg  <= '0;
            bidx_reg <= '0;
            pos_reg  <= '0;
        end else if (cmd.update) begin
            if (pos_reg == '0) begin
                max_reg  <= x_reg;
                sum_reg  <= SUM_ONE;
                best_reg <= x_reg;
                bidx_reg <= '0;
            end else begin
                if (gt_max) begin
                    sum_reg <= (grow > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : grow[31:0];
                    max_reg <= x_reg;
                end else begin
                    sum_reg <= addsum[32] ? 32'hFFFF_FFFF : addsum[31:0];
                end
                if (pos_reg < ncls_reg && 32'(pos_reg) < 32'(MAX_CLASSES)
                    && x_reg > best_reg) begin
                    best_reg <= x_reg;
                    bidx_reg <= pos_reg[7:0];
                end
            end
            if (pos_reg != POS_SAT) begin
                pos_reg <= pos_reg + 9'd1;
            end
        end
    end

    // Restoring divider: 33-bit quotient of (E << 16) / sum, one bit a cycle.
    logic [32:0] quo_reg;
    logic [32:0] num_reg;
    logic [32:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        zero_reg;
    logic [16:0] sdmag, e_sc;
    logic [17:0] sidx;
    logic [33:0] trial;

    always_comb begin
        sdmag = 17'(max_reg) - 17'(best_reg);
        sidx  = ({1'b0, sdmag} + 18'd2) >> 2;
        e_sc  = exp_lookup(sdmag, exp_rom[sidx[IDX_W-1:0]]);
        trial = {rem_reg, num_reg[32]} - {2'b0, sum_reg};
    end

    always_ff @(posedge clk) begin
        if (cmd.div_start) begin
            num_reg  <= {e_sc, 16'd0};
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            zero_reg <= (sum_reg == '0);
        end else if (cmd.div_step && cnt_reg != 6'd33) begin
            if (!trial[33]) begin
                rem_reg <= trial[32:0];
                quo_reg <= {quo_reg[31:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[31:0], num_reg[32]};
                quo_reg <= {quo_reg[31:0], 1'b0};
            end
            num_reg <= {num_reg[31:0], 1'b0};
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    logic [15:0] sc;
    always_comb begin
        sc = (zero_reg || quo_reg > 33'd65535) ? 16'hFFFF : quo_reg[15:0];
    end

    // Box conversion, one multiplier per axis value.
    function automatic logic [18:0] corner(input logic [15:0] c, input logic [15:0] s,
                                           input logic [13:0] k);
        logic signed [17:0] t;
        logic signed [32:0] v;
        t = signed'({1'b0, c, 1'b0}) - signed'({2'b0, s});
        v = t * signed'({1'b0, k}) + 33'sd4096;
        return v[31:13];
    endfunction

    function automatic logic [17:0] span(input logic [15:0] s, input logic [13:0] k);
        logic [30:0] v;
        v = 31'(s) * 31'(k) + 31'd2048;
        return v[29:12];
    endfunction

    always_ff @(posedge clk) begin
        if (cmd.box) begin
            x_left     <= corner(cx_reg, w_reg, imw_reg);
            y_top      <= corner(cy_reg, h_reg, imh_reg);
            box_width  <= span(w_reg, imw_reg);
            box_height <= span(h_reg, imh_reg);
            score      <= sc;
            class_id   <= bidx_reg;
        end
    end

    assign status.is_last  = last_reg;
    assign status.div_done = (cnt_reg == 6'd33);
    assign status.pass     = (sc >= thr_reg);

endmodule

>>> hw/rtl/detection_query_decoder.sv
`timescale 1ns / 1ps
// Detection query decoder: streams class logits (Q7.8) of one query, keeps an
// online softmax and argmax, and at the request marked last_in_query emits at
// most one detection (class, Q0.16 score, corner box in Q.4 pixels) when the
// score reaches score_threshold. A request passes capture and update; a last
// request then loads the divider, runs the bit-serial score divider (33
// quotient bits, then a done state), converts the box and, if the score
// passes, presents the result, so the shared divider sets the per-query cost.
// The result register holds while stalled. Configuration writes are not held
// off, so they should be made only while no request is in flight.
module detection_query_decoder #(
    parameter int unsigned MAX_CLASSES     = 256,
    parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  logit,
    input  logic                last_in_query,
    input  logic [15:0]         center_x,
    input  logic [15:0]         center_y,
    input  logic [15:0]         norm_width,
    input  logic [15:0]         norm_height,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [18:0]  x_left,
    output logic signed [18:0]  y_top,
    output logic [17:0]         box_width,
    output logic [17:0]         box_height,
    output logic [15:0]         score,
    output logic [7:0]          class_id
);
    import dqd_pkg::*;

    dqd_cmd_t    cmd;
    dqd_status_t status;

    // The index port spans exactly the four registers, so every index is known.
    dqd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    dqd_datapath #(
        .MAX_CLASSES     (MAX_CLASSES),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_sel       (cfg_index),
        .cfg_known     (1'b1),
        .cfg_data      (cfg_data),
        .logit         (logit),
        .last_in_query (last_in_query),
        .center_x      (center_x),
        .center_y      (center_y),
        .norm_width    (norm_width),
        .norm_height   (norm_height),
        .x_left        (x_left),
        .y_top         (y_top),
        .box_width     (box_width),
        .box_height    (box_height),
        .score         (score),
        .class_id      (class_id)
    );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import dqd_pkg::*;

    // Bounds used by the scoring predictor.
    localparam int unsigned CLASS_LIMIT = 256;
    localparam int unsigned ROM_DEPTH   = 1024;
    localparam longint unsigned RATIO_Q32 = 64'd4228380000;
    // Cycles a last request may spend inside the block after the final result.
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    // One detection as it leaves the block.
    typedef struct {
        logic [18:0] x_left;
        logic [18:0] y_top;
        logic [17:0] box_width;
        logic [17:0] box_height;
        logic [15:0] score;
        logic [7:0]  class_id;
    } detection_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] logit;
    logic last_in_query;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] norm_width;
    logic [15:0] norm_height;
    logic out_valid;
    logic out_stall;
    logic signed [18:0] x_left;
    logic signed [18:0] y_top;
    logic [17:0] box_width;
    logic [17:0] box_height;
    logic [15:0] score;
    logic [7:0] class_id;

    detection_query_decoder DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .logit(logit),
        .last_in_query(last_in_query),
        .center_x(center_x),
        .center_y(center_y),
        .norm_width(norm_width),
        .norm_height(norm_height),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .x_left(x_left),
        .y_top(y_top),
        .box_width(box_width),
        .box_height(box_height),
        .score(score),
        .class_id(class_id)
    );

    // Configuration as the predictor believes it to be.
    logic [15:0] cur_threshold;
    logic [8:0]  cur_classes;
    logic [13:0] cur_img_w;
    logic [13:0] cur_img_h;

    // Per-query softmax state of the predictor.
    logic signed [15:0] soft_max;
    logic [31:0]        soft_sum;
    logic signed [15:0] top_logit;
    logic [7:0]         top_class;
    logic [8:0]         position;

    logic [31:0] exp_rom [ROM_DEPTH];
    detection_t  pending_detections [$];

    bit idle_enabled;
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned request_count;
    int unsigned query_count;
    int unsigned detection_count;

    // Block outputs captured at the falling edge, so that every
    // decision at a rising edge sees the settled pre-edge values.
    logic in_stall_q;
    logic out_valid_q;
    detection_t seen_q;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        in_stall_q  <= in_stall;
        out_valid_q <= out_valid;
        seen_q      <= '{x_left, y_top, box_width, box_height, score, class_id};
    end

    // Exponential ROM: entry i approximates exp(-i/64) in Q1.16.
    function automatic void build_exp_rom();
        longint unsigned e;
        e = 64'd1 << 32;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            exp_rom[i] = 32'((e + 64'd32768) >> 16);
            e = (((e >> 1) * RATIO_Q32) + (64'd1 << 30)) >> 31;
        end
    endfunction

    // Lookup of exp(-d) for a non-negative Q7.8 difference.
    function automatic longint unsigned exp_of_gap(int d);
        int unsigned idx;
        idx = (d + 2) >> 2;
        if (idx >= ROM_DEPTH)
            return 0;
        return exp_rom[idx];
    endfunction

    function automatic logic [31:0] saturate_sum(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
    endfunction

    // Corner coordinate: round((2c - s) * scale / 2^13) half up, 19 bits.
    function automatic logic [18:0] corner_of(int unsigned c, int unsigned s,
                                              int unsigned scale);
        longint v;
        v = (longint'(2 * c) - longint'(s)) * longint'(scale);
        v = (v + 4096) >>> 13;
        return v[18:0];
    endfunction

    function automatic void clear_query_state();
        soft_max  = '0;
        soft_sum  = '0;
        top_logit = '0;
        top_class = '0;
        position  = '0;
    endfunction

    // Advance the predictor by one accepted request and queue the detection
    // it produces, if any.
    function automatic void score_request(logic signed [15:0] x, logic last,
                                          logic [15:0] cx, logic [15:0] cy,
                                          logic [15:0] w, logic [15:0] h);
        longint unsigned scaled;
        longint unsigned num;
        longint unsigned quotient;
        logic [15:0] sc;
        logic [7:0] cls;
        detection_t d;
        if (position == 0)
        begin
            soft_max  = x;
            soft_sum  = 32'd65536;
            top_logit = x;
            top_class = '0;
        end
        else
        begin
            if (x > soft_max)
            begin
                scaled = (longint'(soft_sum) * exp_of_gap(int'(x) - int'(soft_max))
                          + 64'd32768) >> 16;
                soft_sum = saturate_sum(scaled + 64'd65536);
                soft_max = x;
            end
            else
            begin
                soft_sum = saturate_sum(longint'(soft_sum)
                                        + exp_of_gap(int'(soft_max) - int'(x)));
            end
            if (position < cur_classes && position < CLASS_LIMIT && x > top_logit)
            begin
                top_logit = x;
                top_class = position[7:0];
            end
        end
        if (position < 9'd511)
            position++;
        if (!last)
            return;
        query_count++;
        num = exp_of_gap(int'(soft_max) - int'(top_logit)) << 16;
        quotient = (soft_sum != 0) ? num / soft_sum : 64'd65535;
        sc = (quotient > 64'd65535) ? 16'hFFFF : quotient[15:0];
        cls = top_class;
        clear_query_state();
        if (sc < cur_threshold)
            return;
        d.x_left     = corner_of(cx, w, cur_img_w);
        d.y_top      = corner_of(cy, h, cur_img_h);
        d.box_width  = 18'((longint'(w) * cur_img_w + 2048) >> 12);
        d.box_height = 18'((longint'(h) * cur_img_h + 2048) >> 12);
        d.score      = sc;
        d.class_id   = cls;
        pending_detections.push_back(d);
    endfunction

    // Sends one request and waits until the block takes it.
    task automatic send_request(logic signed [15:0] x, logic last,
                                logic [15:0] cx, logic [15:0] cy,
                                logic [15:0] w, logic [15:0] h);
        while (idle_enabled && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        logit         <= x;
        last_in_query <= last;
        center_x      <= cx;
        center_y      <= cy;
        norm_width    <= w;
        norm_height   <= h;
        @(posedge clk);
        while (in_stall_q)
            @(posedge clk);
        request_count++;
        score_request(x, last, cx, cy, w, h);
    endtask

    // Lets the block drain: every detection in, then time for a last request
    // that was dropped below the threshold to finish its divide.
    task automatic wait_until_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_detections.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] value);
        wait_until_quiet();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_THRESHOLD: cur_threshold = value;
            REG_CLASSES:   cur_classes   = value[8:0];
            REG_WIDTH:     cur_img_w     = value[13:0];
            REG_HEIGHT:    cur_img_h     = value[13:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] th, logic [8:0] classes,
                              logic [13:0] w, logic [13:0] h);
        write_register(REG_THRESHOLD, th);
        write_register(REG_CLASSES, 16'(classes));
        write_register(REG_WIDTH, 16'(w));
        write_register(REG_HEIGHT, 16'(h));
    endtask

    // One query whose logits mostly hover near a base value, with a peak at one
    // position so that the softmax score often clears a moderate threshold.
    task automatic send_peaked_query(int len);
        int peak;
        int base;
        int v;
        peak = $urandom_range(len - 1);
        base = $urandom_range(4000) - 2000;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                v = $urandom_range(65535) - 32768;
            else if (i == peak)
                v = base + $urandom_range(3000);
            else
                v = base + $urandom_range(600) - 300;
            send_request(16'(v), i == len - 1, 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
        end
    endtask

    // Results from the block are compared with the oldest predicted detection.
    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        detection_t want;
        if (rst_n && out_valid_q && !out_stall)
        begin
            if (pending_detections.size() == 0)
            begin
                $error("detection with no request waiting for one");
                error_count++;
            end
            else
            begin
                want = pending_detections.pop_front();
                detection_count++;
                check_field("x_left", want.x_left, seen_q.x_left);
                check_field("y_top", want.y_top, seen_q.y_top);
                check_field("box_width", want.box_width, seen_q.box_width);
                check_field("box_height", want.box_height, seen_q.box_height);
                check_field("score", want.score, seen_q.score);
                check_field("class_id", want.class_id, seen_q.class_id);
            end
        end
    end

    // The receiving side stalls at random while idling is enabled.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= idle_enabled && ($urandom_range(99) < 14);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Queries under the reset configuration, before any register write.
    task automatic test_reset_config();
        send_request(16'sd3000, 1'b1, 16'h8000, 16'h8000, 16'h4000, 16'h2000);
        send_request(16'sd0, 1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_request(16'sd2560, 1'b1, 16'h1234, 16'hFEDC, 16'h0100, 16'hFFFF);
        for (int q = 0; q < 4; q++)
            send_peaked_query($urandom_range(1, 6));
    endtask

    // Field extremes, argmax ties, position zero, table range and zero sizes.
    task automatic test_directed();
        set_config(16'd0, 9'd256, 14'd8192, 14'd8192);
        send_request(16'sh7FFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(-16'sh8000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(16'sh0000, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        // The gap to the largest logit lands beyond the end of the exponential table.
        send_request(-16'sh8000, 1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_request(16'sh7FFF, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        // Tied logits keep the lower class index.
        send_request(16'sd100, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(16'sd900, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(16'sd900, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(16'sd900, 1'b1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        // One class allowed: position zero stays the best.
        write_register(REG_CLASSES, 16'd1);
        send_request(-16'sd500, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(16'sd2000, 1'b1, 16'h4000, 16'hC000, 16'h8000, 16'h8000);
        // Zero classes behave the same way.
        write_register(REG_CLASSES, 16'd0);
        send_request(-16'sd100, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(16'sd100, 1'b1, 16'h8000, 16'h8000, 16'h1000, 16'h1000);
        // Zero image size collapses the box on that axis.
        write_register(REG_WIDTH, 16'd0);
        write_register(REG_HEIGHT, 16'd1);
        write_register(REG_CLASSES, 16'd2);
        send_request(16'sd50, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(16'sd60, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // The highest threshold needs a certain score.
        write_register(REG_THRESHOLD, 16'hFFFF);
        send_request(16'sd700, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_request(16'sd700, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(16'sd700, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    endtask

    // A query longer than the position counter: later logits only feed the maximum and sum.
    task automatic test_long_query();
        set_config(16'd0, 9'd256, 14'd640, 14'd480);
        for (int i = 0; i < 600; i++)
            send_request((i > 520) ? 16'sd4000 : 16'(-100 + (i % 7)), i == 599,
                         16'h6000, 16'h7000, 16'h2000, 16'h3000);
    endtask

    // Random phases, each under its own configuration.
    task automatic test_random(int target);
        int start;
        int phase;
        int len;
        logic [15:0] th;
        logic [8:0] classes;
        logic [13:0] w;
        logic [13:0] h;
        start = request_count;
        phase = 0;
        while (request_count - start < target)
        begin
            case ($urandom_range(5))
                0: th = 16'd0;
                1: th = 16'hFFFF;
                2: th = 16'($urandom);
                default: th = 16'($urandom_range(16000));
            endcase
            case ($urandom_range(4))
                0: classes = 9'd1;
                1: classes = 9'd256;
                default: classes = 9'($urandom_range(1, 256));
            endcase
            w = ($urandom_range(5) == 0) ? 14'd8192 : 14'($urandom_range(1, 8192));
            h = ($urandom_range(5) == 0) ? 14'd8192 : 14'($urandom_range(1, 8192));
            if ($urandom_range(9) == 0)
                w = 14'd0;
            set_config(th, classes, w, h);
            // One phase runs with no idling on either side.
            idle_enabled = (phase != 1);
            for (int k = 0; k < 30 && request_count - start < target; k++)
            begin
                if ($urandom_range(19) == 0)
                    len = $urandom_range(20, 300);
                else
                    len = $urandom_range(1, 12);
                send_peaked_query(len);
            end
            idle_enabled = 1'b1;
            phase++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        logit = '0;
        last_in_query = 1'b0;
        center_x = '0;
        center_y = '0;
        norm_width = '0;
        norm_height = '0;
        out_stall = 1'b0;
        in_stall_q = 1'b1;
        out_valid_q = 1'b0;
        idle_enabled = 1'b1;
        cycle_count = 0;
        error_count = 0;
        request_count = 0;
        query_count = 0;
        detection_count = 0;
        cur_threshold = 16'd32768;
        cur_classes = 9'd80;
        cur_img_w = 14'd640;
        cur_img_h = 14'd640;
        build_exp_rom();
        clear_query_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_directed();
        test_long_query();
        test_random(1200);

        wait_until_quiet();
        $display("Sent %0d requests in %0d queries; checked %0d detections.",
                 request_count, query_count, detection_count);
        $display("Covered field extremes, ties, class limits, zero sizes and long queries.");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
